@@ hdl/blb_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucketed length batcher package
// Shared widths, register indexes, word types and the control interface
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package blb_pkg;

  localparam int NUM_BUCKETS_DEF = 4;
  localparam int MAX_BATCH_DEF   = 16;

  localparam int KeyW    = 16;
  localparam int TagW    = 32;
  localparam int BoundW  = 16;
  localparam int LimW    = 5;
  localparam int CfgW    = BoundW + LimW;
  localparam int CfgIdxW = 3;
  localparam int CntW    = 16;

  localparam int NumBucketRegs = 4;

  localparam logic [CfgIdxW-1:0] CFG_BUCKET_0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUCKET_1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BUCKET_2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BUCKET_3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FLUSH_N   = 3'd4;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_END    = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [KeyW-1:0] length_key;
    logic [TagW-1:0] sample_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      src_bucket;
    logic [KeyW-1:0] elem_key;
    logic [TagW-1:0] elem_tag;
    logic            batch_end;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic append;
    logic select;
    logic prep;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic drop;
    logic rec_full;
    logic pend_any;
    logic out_free;
    logic elem_last;
  } dp_status_t;

  function automatic logic [CfgW-1:0] bucket_reset(input int b);
    logic [BoundW-1:0] bound;
    bound = BoundW'(64 << b);
    return {LimW'(16), bound};
  endfunction

endpackage

`default_nettype wire

@@ hdl/bucketed_length_batcher.sv @@
// ----------------------------------------------------------------------------
// Bucketed length batcher
// Sorts records into length buckets and emits each bucket as a batch when it
// fills, on a periodic count of records, or at end of input.
// ----------------------------------------------------------------------------
// A dropped record frees the input after the append state, other words without
// output after append and selection. A full bucket's first element is offered
// after append, store read and emit, a flush's after a selection too; then one
// element follows per cycle while the output is not stalled, with a selection
// and a store read between buckets and one selection at the end.
// Reset restores the bucket settings and clears the fill counts and counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_length_batcher #(
  parameter int NumBuckets = blb_pkg::NUM_BUCKETS_DEF,
  parameter int MaxBatch   = blb_pkg::MAX_BATCH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire blb_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output blb_pkg::out_item_t               out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [blb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [blb_pkg::CfgW-1:0]    cfg_data_i
);
  import blb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  blb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  blb_datapath #(
    .NumBuckets (NumBuckets),
    .MaxBatch   (MaxBatch)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word taken while the previous one is still being appended");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while its word is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load))
    else $error("output word appeared without an element load");

endmodule

`default_nettype wire

@@ hdl/blb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bucketed length batcher sequencer
// Steps each word through accept, append, bucket selection, store read and
// element emission, issuing commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module blb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire blb_pkg::dp_status_t status_i,
  output blb_pkg::ctrl_cmd_t       cmd_o
);
  import blb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_SELECT = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        if (status_i.drop) begin
          state_d = S_IDLE;
        end else if (status_i.rec_full) begin
          state_d = S_PREP;
        end else begin
          state_d = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd_o.select = 1'b1;
        state_d = status_i.pend_any ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.load = status_i.out_free;
        if (status_i.out_free && status_i.elem_last) begin
          state_d = S_SELECT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/blb_datapath.sv @@
// ----------------------------------------------------------------------------
// Bucketed length batcher datapath
// Holds the bucket settings, fill counts, flush counter, the element store
// and the output register, and carries out the sequencer's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module blb_datapath #(
  parameter int NumBuckets = blb_pkg::NUM_BUCKETS_DEF,
  parameter int MaxBatch   = blb_pkg::MAX_BATCH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire blb_pkg::ctrl_cmd_t           cmd_i,
  output blb_pkg::dp_status_t               status_o,
  input  wire blb_pkg::in_item_t            in_data_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [blb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [blb_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output blb_pkg::out_item_t                out_data_o
);
  import blb_pkg::*;

  localparam int BW    = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int IdxW  = (MaxBatch > 1) ? $clog2(MaxBatch) : 1;
  localparam int FW    = $clog2(MaxBatch + 1);
  localparam int AddrW = BW + IdxW;
  localparam int Depth = 2 ** AddrW;

  logic [CfgW-1:0]       bcfg_q [NumBuckets];
  logic [CntW-1:0]       flush_n_q;
  logic [FW-1:0]         fill_q [NumBuckets];
  logic [CntW-1:0]       cnt_q;
  logic [NumBuckets-1:0] pend_q;
  logic                  out_valid_q;

  logic                  type_q;
  logic [KeyW-1:0]       key_q;
  logic [TagW-1:0]       tag_q;
  logic                  hit_q;
  logic [BW-1:0]         id_q;
  logic [BW-1:0]         cur_q;
  logic [IdxW-1:0]       ptr_q;
  out_item_t             out_q;

  entry_t                mem_q [Depth];
  entry_t                rd_q;

  logic                  hit_d;
  logic [BW-1:0]         id_d;
  logic [FW-1:0]         fill_cur;
  logic [FW-1:0]         slot;
  logic [FW-1:0]         fill_new;
  logic [LimW-1:0]       lim_raw;
  logic [LimW-1:0]       lim_eff;
  logic                  full;
  logic [NumBuckets-1:0] id_mask;
  logic [NumBuckets-1:0] nonempty;
  logic [NumBuckets-1:0] nonempty_new;
  logic [CntW-1:0]       cnt_inc;
  logic                  periodic;
  logic                  rec_hit;
  logic [BW-1:0]         sel_b;
  logic [NumBuckets-1:0] sel_mask;
  logic                  elem_last;
  logic                  out_free;
  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;
  logic [IdxW-1:0]       ptr_next;

  always_comb begin
    hit_d = 1'b0;
    id_d  = '0;
    for (int b = NumBuckets - 1; b >= 0; b--) begin
      if (bcfg_q[b][BoundW-1:0] >= in_data_i.length_key) begin
        hit_d = 1'b1;
        id_d  = BW'(b);
      end
    end
  end

  always_comb begin
    fill_cur = fill_q[id_q];
    slot     = (fill_cur >= FW'(MaxBatch)) ? FW'(MaxBatch - 1) : fill_cur;
    fill_new = slot + FW'(1);
    lim_raw  = bcfg_q[id_q][CfgW-1:BoundW];
    if (lim_raw == '0) begin
      lim_eff = LimW'(1);
    end else if (lim_raw > LimW'(MaxBatch)) begin
      lim_eff = LimW'(MaxBatch);
    end else begin
      lim_eff = lim_raw;
    end
    full    = LimW'(fill_new) >= lim_eff;
    id_mask = NumBuckets'(1) << id_q;
    for (int b = 0; b < NumBuckets; b++) begin
      nonempty[b] = fill_q[b] != '0;
    end
    nonempty_new = nonempty | id_mask;
    cnt_inc  = (cnt_q == {CntW{1'b1}}) ? cnt_q : cnt_q + CntW'(1);
    periodic = (flush_n_q != '0) && (cnt_inc >= flush_n_q);
    rec_hit  = (type_q == REQ_RECORD) && hit_q;
  end

  always_comb begin
    sel_b    = '0;
    sel_mask = '0;
    for (int b = NumBuckets - 1; b >= 0; b--) begin
      if (pend_q[b]) begin
        sel_b    = BW'(b);
        sel_mask = NumBuckets'(1) << b;
      end
    end
  end

  assign elem_last = ((FW + 1)'(ptr_q) + (FW + 1)'(1)) == {1'b0, fill_q[cur_q]};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign ptr_next  = ptr_q + IdxW'(1);
  assign rd_en     = cmd_i.prep || (cmd_i.load && !elem_last);
  assign rd_addr   = cmd_i.prep ? {cur_q, {IdxW{1'b0}}} : {cur_q, ptr_next};

  assign status_o.drop      = (type_q == REQ_RECORD) && !hit_q;
  assign status_o.rec_full  = rec_hit && full;
  assign status_o.pend_any  = pend_q != '0;
  assign status_o.out_free  = out_free;
  assign status_o.elem_last = elem_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBuckets; b++) begin
        bcfg_q[b] <= bucket_reset(b);
        fill_q[b] <= '0;
      end
      flush_n_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        for (int b = 0; b < NumBuckets; b++) begin
          if (b < NumBucketRegs && cfg_index_i == CfgIdxW'(b)) begin
            bcfg_q[b] <= cfg_data_i;
          end
        end
        if (cfg_index_i == CFG_FLUSH_N) begin
          flush_n_q <= cfg_data_i[CntW-1:0];
        end
      end

      if (cmd_i.append) begin
        if (type_q == REQ_END) begin
          pend_q <= nonempty;
          cnt_q  <= '0;
        end else if (hit_q) begin
          fill_q[id_q] <= fill_new;
          cnt_q        <= periodic ? '0 : cnt_inc;
          if (full) begin
            pend_q <= periodic ? (nonempty_new & ~id_mask) : '0;
          end else begin
            pend_q <= periodic ? nonempty_new : '0;
          end
        end
      end

      if (cmd_i.select) begin
        pend_q <= pend_q & ~sel_mask;
      end

      if (cmd_i.load && elem_last) begin
        fill_q[cur_q] <= '0;
      end

      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q <= in_data_i.req_type;
      key_q  <= in_data_i.length_key;
      tag_q  <= in_data_i.sample_tag;
      hit_q  <= hit_d;
      id_q   <= id_d;
    end
    if (cmd_i.append) begin
      cur_q <= id_q;
    end else if (cmd_i.select) begin
      cur_q <= sel_b;
    end
    if (cmd_i.prep) begin
      ptr_q <= '0;
    end else if (cmd_i.load) begin
      ptr_q <= ptr_next;
    end
    if (cmd_i.load) begin
      out_q.src_bucket <= 2'(cur_q);
      out_q.elem_key   <= rd_q.key;
      out_q.elem_tag   <= rd_q.tag;
      out_q.batch_end  <= elem_last;
      out_q.last       <= elem_last && (pend_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && rec_hit) begin
      mem_q[{id_q, IdxW'(slot)}] <= '{key: key_q, tag: tag_q};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ sim/tb_bucketed_length_batcher.sv @@
// ----------------------------------------------------------------------------
// Bucketed length batcher testbench
// Sends record and end-of-input words through the batcher. The sender and the
// receiver both idle at random, and the bucket registers are rewritten between
// phases. A behavioural copy of the bucket state predicts every batch element,
// and the output stream is checked against it in order.
// ----------------------------------------------------------------------------

module tb_bucketed_length_batcher;
  import blb_pkg::*;

  localparam int NB          = NUM_BUCKETS_DEF;
  localparam int MB          = MAX_BATCH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 12;
  localparam int CNT_MAX     = 2 ** CntW - 1;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  in_item_t           in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  bucketed_length_batcher u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Behavioural copy of the batcher.
  logic [CfgW-1:0] bkt_cfg [NB];
  logic [CntW-1:0] flush_every;
  logic [KeyW-1:0] bkt_key [NB][MB];
  logic [TagW-1:0] bkt_tag [NB][MB];
  int              bkt_fill [NB];
  int              since_flush;

  in_item_t  word_q [$];
  out_item_t batch_elems_q [$];
  out_item_t want;

  bit in_taken    = 1'b0;
  bit calm        = 1'b0;
  bit send_quiet  = 1'b0;
  bit recv_quiet  = 1'b0;
  int send_gap    = 0;
  int recv_gap    = 0;
  int hold_asks   = 0;
  int hold_served = 0;
  int cycles      = 0;
  int fails       = 0;
  int words_in    = 0;
  int elems_out   = 0;
  int reg_writes  = 0;

  function automatic int limit_of(int b);
    int lim;
    lim = int'(bkt_cfg[b][CfgW-1:BoundW]);
    if (lim == 0) lim = 1;
    if (lim > MB) lim = MB;
    return lim;
  endfunction

  function automatic int pick_bucket(logic [KeyW-1:0] key);
    for (int b = 0; b < NB; b++) begin
      if (bkt_cfg[b][BoundW-1:0] >= key) return b;
    end
    return -1;
  endfunction

  task automatic emit_batch(int b);
    out_item_t e;
    for (int k = 0; k < bkt_fill[b]; k++) begin
      e.src_bucket = 2'(b);
      e.elem_key   = bkt_key[b][k];
      e.elem_tag   = bkt_tag[b][k];
      e.batch_end  = (k == bkt_fill[b] - 1);
      e.last       = 1'b0;
      batch_elems_q.insert(batch_elems_q.size(), e);
    end
    bkt_fill[b] = 0;
  endtask

  task automatic flush_buckets();
    for (int b = 0; b < NB; b++) begin
      if (bkt_fill[b] != 0) emit_batch(b);
    end
  endtask

  task automatic batcher_step(in_item_t w);
    int        n0;
    int        b;
    int        f;
    n0 = batch_elems_q.size();
    if (w.req_type == REQ_END) begin
      flush_buckets();
      since_flush = 0;
    end else begin
      b = pick_bucket(w.length_key);
      if (b < 0) return;
      f = bkt_fill[b];
      if (f >= MB) f = MB - 1;
      bkt_key[b][f] = w.length_key;
      bkt_tag[b][f] = w.sample_tag;
      bkt_fill[b] = f + 1;
      if (bkt_fill[b] >= limit_of(b)) emit_batch(b);
      if (since_flush < CNT_MAX) since_flush++;
      if (flush_every != 0 && since_flush >= flush_every) begin
        flush_buckets();
        since_flush = 0;
      end
    end
    if (batch_elems_q.size() > n0) begin
      batch_elems_q[batch_elems_q.size() - 1].last = 1'b1;
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FLUSH_N) flush_every = data[CntW-1:0];
    else if (idx < NumBucketRegs && idx < NB) bkt_cfg[idx] = data;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_word(logic rt, logic [KeyW-1:0] key, logic [TagW-1:0] tag);
    in_item_t w;
    w.req_type   = rt;
    w.length_key = key;
    w.sample_tag = tag;
    word_q.insert(word_q.size(), w);
  endtask

  // Waits until every word has been taken and every element has come out,
  // then gives a dropped word time to leave the pipeline.
  task automatic drain();
    while (word_q.size() != 0 || in_valid || batch_elems_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_settings();
    int               acc;
    logic [BoundW-1:0] bnd;
    logic [LimW-1:0]   lim;
    logic [CfgIdxW-1:0] idx;
    logic [CntW-1:0]   fl;
    acc = $urandom_range(0, 200);
    for (int b = 0; b < NB; b++) begin
      acc = acc + $urandom_range(0, 4000);
      if (acc > CNT_MAX) acc = CNT_MAX;
      bnd = BoundW'(acc);
      if ($urandom_range(0, 4) == 0) bnd = BoundW'($urandom);
      if (b == NB - 1 && $urandom_range(0, 2) == 0) bnd = '1;
      lim = ($urandom_range(0, 3) == 0) ? LimW'($urandom_range(0, 31))
                                        : LimW'($urandom_range(1, 4));
      case (b)
        0:       idx = CFG_BUCKET_0;
        1:       idx = CFG_BUCKET_1;
        2:       idx = CFG_BUCKET_2;
        default: idx = CFG_BUCKET_3;
      endcase
      write_reg(idx, {lim, bnd});
    end
    case ($urandom_range(0, 5))
      0, 1:    fl = '0;
      5:       fl = '1;
      default: fl = CntW'($urandom_range(1, 12));
    endcase
    write_reg(CFG_FLUSH_N, {LimW'($urandom), fl});
  endtask

  // Mostly keys that land in a bucket, with bounds and the word just above
  // them mixed in. Dropped records do not count towards the total.
  task automatic random_words(int count);
    int               made;
    int               j;
    int               pick;
    logic [KeyW-1:0]   key;
    logic [BoundW-1:0] bnd;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_word(REQ_END, KeyW'($urandom), $urandom);
        made++;
      end else begin
        j    = $urandom_range(0, NB - 1);
        bnd  = bkt_cfg[j][BoundW-1:0];
        pick = $urandom_range(0, 9);
        if (pick < 7)       key = KeyW'($urandom_range(0, bnd));
        else if (pick == 7) key = bnd;
        else if (pick == 8) key = bnd + 1'b1;
        else                key = KeyW'($urandom);
        queue_word(REQ_RECORD, key, $urandom);
        if (pick_bucket(key) >= 0) made++;
      end
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d elements outstanding.",
               cycles, batch_elems_q.size());
      $display("[bucketed_length_batcher] ERROR");
      $finish;
    end
  end

  // Sender.
  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!calm && !send_quiet && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= word_q[0];
      end else begin
        in_valid <= 1'b0;
      end
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    end
  end

  // Receiver.
  always @(negedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      recv_gap = LONG_HOLD;
    end
    if (recv_gap != 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!calm && !recv_quiet && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
  end

  // Checker and predictor.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (batch_elems_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("Unexpected element: bucket %0d key %h tag %h end %b last %b",
                     out_data.src_bucket, out_data.elem_key, out_data.elem_tag,
                     out_data.batch_end, out_data.last);
          end
        end else begin
          want = batch_elems_q.pop_front();
          if (out_data.src_bucket !== want.src_bucket ||
              out_data.elem_key !== want.elem_key ||
              out_data.elem_tag !== want.elem_tag ||
              out_data.batch_end !== want.batch_end ||
              out_data.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("Element %0d wrong: expected b%0d %h %h end %b last %b, got b%0d %h %h end %b last %b",
                       elems_out, want.src_bucket, want.elem_key, want.elem_tag,
                       want.batch_end, want.last, out_data.src_bucket,
                       out_data.elem_key, out_data.elem_tag, out_data.batch_end,
                       out_data.last);
            end
          end
          elems_out++;
        end
      end
      if (in_valid && !in_stall) begin
        batcher_step(in_data);
        void'(word_q.pop_front());
        words_in++;
        in_taken = 1'b1;
      end
    end
  end

  initial begin
    for (int b = 0; b < NB; b++) begin
      bkt_cfg[b]  = {LimW'(16), BoundW'(64 << b)};
      bkt_fill[b] = 0;
    end
    flush_every = '0;
    since_flush = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: bounds and keys just past them, two drops, end of input
    // with occupied and with empty buckets.
    queue_word(REQ_RECORD, 16'd0, 32'h0);
    queue_word(REQ_RECORD, 16'd64, 32'hFFFF_FFFF);
    queue_word(REQ_RECORD, 16'd65, $urandom);
    queue_word(REQ_RECORD, 16'd256, $urandom);
    queue_word(REQ_RECORD, 16'd512, $urandom);
    queue_word(REQ_RECORD, 16'd513, $urandom);
    queue_word(REQ_RECORD, 16'hFFFF, $urandom);
    queue_word(REQ_END, 16'h0, 32'h0);
    queue_word(REQ_END, 16'hFFFF, 32'hFFFF_FFFF);
    queue_word(REQ_RECORD, 16'd100, $urandom);
    drain();

    // A zero limit, a limit above the maximum and bounds out of order.
    write_reg(CFG_BUCKET_0, {LimW'(0), BoundW'(0)});
    write_reg(CFG_BUCKET_1, {LimW'(31), BoundW'(16'hFFFF)});
    write_reg(CFG_BUCKET_2, {LimW'(2), BoundW'(10)});
    write_reg(CFG_BUCKET_3, '1);
    write_reg(CFG_FLUSH_N, '0);
    queue_word(REQ_RECORD, 16'd0, $urandom);
    queue_word(REQ_RECORD, 16'd1, $urandom);
    queue_word(REQ_RECORD, 16'd2, $urandom);
    queue_word(REQ_RECORD, 16'd5, $urandom);
    drain();

    // The limit drops below the fill, so the next record emits the bucket.
    write_reg(CFG_BUCKET_1, {LimW'(2), BoundW'(16'hFFFF)});
    queue_word(REQ_RECORD, 16'd7, $urandom);
    drain();

    // A periodic flush and a full bucket on separate records.
    write_reg(CFG_BUCKET_1, {LimW'(2), BoundW'(20)});
    write_reg(CFG_BUCKET_2, {LimW'(4), BoundW'(40)});
    write_reg(CFG_FLUSH_N, {LimW'(0), CntW'(3)});
    queue_word(REQ_RECORD, 16'd30, $urandom);
    queue_word(REQ_RECORD, 16'd15, $urandom);
    queue_word(REQ_RECORD, 16'd15, $urandom);
    drain();

    write_reg(CFG_FLUSH_N, {LimW'(0), CntW'(1)});
    queue_word(REQ_RECORD, 16'd40000, $urandom);
    queue_word(REQ_RECORD, 16'd12, $urandom);
    drain();

    // Writes to unused indexes must leave the settings alone.
    write_reg(CFG_SPARE_LO, CfgW'($urandom));
    write_reg(CFG_SPARE_HI, '1);
    write_reg(CFG_FLUSH_N, '1);
    queue_word(REQ_RECORD, 16'd0, $urandom);
    queue_word(REQ_END, KeyW'($urandom), $urandom);
    drain();

    for (int p = 0; p < 6; p++) begin
      random_settings();
      if (p == 5) calm = 1'b1;
      if (p == 2) hold_asks++;
      random_words(28);
      drain();
    end

    queue_word(REQ_END, KeyW'($urandom), $urandom);
    drain();

    $display("Run covered %0d words in and %0d batch elements out, with %0d register writes.",
             words_in, elems_out, reg_writes);
    $display("Mismatches: %0d.", fails);
    if (fails == 0) begin
      $display("[bucketed_length_batcher] OK");
    end else begin
      $display("[bucketed_length_batcher] ERROR");
    end
    $finish;
  end

endmodule
